// ----- sv/epoch_seconds_to_calendar_date_defines.svh -----
// Assertion shorthands for the calendar date block checker.
// All assertions are clocked on aclk and disabled while aresetn is low.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// Same-cycle implication
`define ECD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ECD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ecd_pkg.sv -----
`default_nettype none

package ecd_pkg;

    localparam logic [11:0] EpochYear   = 12'd1970;
    localparam logic [10:0] DaysPerYear = 11'd365;
    localparam logic [10:0] DaysLeap    = 11'd366;
    localparam logic [1:0]  LastYearIdx = 2'd3;
    localparam logic [1:0]  LeapYearIdx = 2'd2;
    localparam logic [3:0]  FebIdx      = 4'd1;
    localparam logic [15:0] WdayOffset  = 16'd4;   // 1970-01-01 was a Thursday

    // constant divisors handled by the shared multiply unit
    typedef enum logic [1:0] {
        DIV_BY_60   = 2'd0,
        DIV_BY_24   = 2'd1,
        DIV_BY_1461 = 2'd2,
        DIV_BY_7    = 2'd3
    } div_sel_t;

    typedef struct packed {
        logic        start;
        div_sel_t    sel;
        logic [31:0] x;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [10:0] rem;
    } div_rsp_t;

    // Reciprocals: q = (x * magic) >> 37 for /60, >> 32 for the others.
    // /60 is exact over all 32-bit x; the others only see small operands.
    function automatic logic [31:0] div_magic(input div_sel_t sel);
        logic [31:0] m;
        unique case (sel)
            DIV_BY_60:   m = 32'h8888_8889;
            DIV_BY_24:   m = 32'd178956971;
            DIV_BY_1461: m = 32'd2939745;
            DIV_BY_7:    m = 32'd613566757;
            default:     m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [10:0] div_divisor(input div_sel_t sel);
        logic [10:0] d;
        unique case (sel)
            DIV_BY_60:   d = 11'd60;
            DIV_BY_24:   d = 11'd24;
            DIV_BY_1461: d = 11'd1461;
            DIV_BY_7:    d = 11'd7;
            default:     d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] idx);
        logic [4:0] len;
        case (idx)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ecd_divu.sv -----
`default_nettype none

// Shared constant divider: one 32x32 multiplier used twice per operation,
// first for the reciprocal product, then for quotient times divisor.
// A new request is taken in the cycle the previous result is shown.
module ecd_divu import ecd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_MUL  = 3'b010,
        PH_BACK = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    div_sel_t    sel_reg;
    logic [31:0] x_reg;
    logic [63:0] prod_reg;
    logic [31:0] quo_reg;

    logic        take;
    logic [31:0] quo_cur;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_next;

    assign take = req.start && (phase_reg == PH_IDLE || phase_reg == PH_BACK);

    assign quo_cur = (sel_reg == DIV_BY_60) ? {5'b0, prod_reg[63:37]} : prod_reg[63:32];

    assign mul_a     = take ? req.x : quo_cur;
    assign mul_b     = take ? div_magic(req.sel) : {21'b0, div_divisor(sel_reg)};
    assign prod_next = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: if (take) phase_next = PH_MUL;
            PH_MUL:  phase_next = PH_BACK;
            PH_BACK: phase_next = take ? PH_MUL : PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg    <= req.x;
            sel_reg  <= req.sel;
            prod_reg <= prod_next;
        end else if (phase_reg == PH_MUL) begin
            quo_reg  <= quo_cur;
            prod_reg <= prod_next;
        end
    end

    // remainder is below 2^11, so the low bits of the difference suffice
    assign rsp.done = (phase_reg == PH_BACK);
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = x_reg[10:0] - prod_reg[10:0];

endmodule

`default_nettype wire

// ----- sv/epoch_seconds_to_calendar_date.sv -----
// Channel   Handshake         Payload
// s_        s_valid/s_ready   s_timestamp (32b unsigned seconds)
// m_        m_valid/m_ready   m_second_of_minute .. m_week_number, m_zone_out
// cfg_      cfg_wr_en         cfg_wr_data (17b signed zone offset)
//
// One timestamp passes from accept to result through seven constant
// divisions on the shared multiplier, 1 to 4 year steps and 1 to 12 month
// steps on a compare/subtract.
// s_ready is high only while the sequencer is idle; the result register lets
// the next timestamp in while an earlier result waits on m_ready.
// Synchronous active-low reset clears the sequencer, m_valid and zone offset.
`default_nettype none

module epoch_seconds_to_calendar_date import ecd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_timestamp,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_second_of_minute,
    output logic [5:0]         m_minute_of_hour,
    output logic [4:0]         m_hour_of_day,
    output logic [4:0]         m_day_of_month,
    output logic [3:0]         m_month_number,
    output logic [11:0]        m_year_number,
    output logic [8:0]         m_ordinal_day,
    output logic [2:0]         m_weekday_number,
    output logic [5:0]         m_week_number,
    output logic signed [16:0] m_zone_out,

    input  logic               cfg_wr_en,
    input  logic signed [16:0] cfg_wr_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SEC   = 12'b000000000010,
        S_MIN   = 12'b000000000100,
        S_HOUR  = 12'b000000001000,
        S_CYC   = 12'b000000010000,
        S_WDAY  = 12'b000000100000,
        S_YEAR  = 12'b000001000000,
        S_MONTH = 12'b000010000000,
        S_JAN   = 12'b000100000000,
        S_JANW  = 12'b001000000000,
        S_WEEK  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t             state_reg, state_next;
    logic signed [16:0] zone_reg;

    logic [5:0]  sec_reg, min_reg;
    logic [4:0]  hour_reg;
    logic [15:0] days_reg;
    logic [5:0]  cyc_reg;
    logic [10:0] rem_reg;
    logic [1:0]  yic_reg;
    logic [8:0]  doy_reg;
    logic [3:0]  month_reg;
    logic [2:0]  wday_reg;
    logic [5:0]  week_reg;
    logic        m_valid_reg;

    div_req_t    req;
    div_rsp_t    rsp;

    logic        s_fire;
    logic        out_free;
    logic        leap;
    logic [4:0]  mlen;
    logic [15:0] jan_base;
    logic [8:0]  ordinal;

    ecd_divu u_divu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // year index 2 of each four-year cycle is the leap year
    assign leap     = (yic_reg == LeapYearIdx);
    assign mlen     = month_len(month_reg) + {4'b0, (leap && month_reg == FebIdx)};
    assign jan_base = days_reg - {7'b0, doy_reg} + WdayOffset;
    assign ordinal  = doy_reg + 9'd1;

    // divider requests
    always_comb begin
        req = '0;
        unique case (state_reg)
            S_IDLE: begin
                req.start = s_fire;
                req.sel   = DIV_BY_60;
                req.x     = s_timestamp;
            end
            S_SEC: begin
                req.start = rsp.done;
                req.sel   = DIV_BY_60;
                req.x     = rsp.quo;
            end
            S_MIN: begin
                req.start = rsp.done;
                req.sel   = DIV_BY_24;
                req.x     = rsp.quo;
            end
            S_HOUR: begin
                req.start = rsp.done;
                req.sel   = DIV_BY_1461;
                req.x     = rsp.quo;
            end
            S_CYC: begin
                req.start = rsp.done;
                req.sel   = DIV_BY_7;
                req.x     = {16'b0, days_reg} + 32'(WdayOffset);
            end
            S_JAN: begin
                req.start = 1'b1;
                req.sel   = DIV_BY_7;
                req.x     = {16'b0, jan_base};
            end
            S_JANW: begin
                req.start = rsp.done;
                req.sel   = DIV_BY_7;
                req.x     = {23'b0, ordinal} + {29'b0, rsp.rem[2:0]};
            end
            default: req = '0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_fire) state_next = S_SEC;
            S_SEC:   if (rsp.done) state_next = S_MIN;
            S_MIN:   if (rsp.done) state_next = S_HOUR;
            S_HOUR:  if (rsp.done) state_next = S_CYC;
            S_CYC:   if (rsp.done) state_next = S_WDAY;
            S_WDAY:  if (rsp.done) state_next = S_YEAR;
            S_YEAR: begin
                if (rem_reg < DaysPerYear || yic_reg == LastYearIdx ||
                    (yic_reg == LeapYearIdx && rem_reg == DaysPerYear)) begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH: if ({6'b0, mlen} > rem_reg) state_next = S_JAN;
            S_JAN:   state_next = S_JANW;
            S_JANW:  if (rsp.done) state_next = S_WEEK;
            S_WEEK:  if (rsp.done) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            zone_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                zone_reg <= cfg_wr_data;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_SEC:  if (rsp.done) sec_reg <= rsp.rem[5:0];
            S_MIN:  if (rsp.done) min_reg <= rsp.rem[5:0];
            S_HOUR: begin
                if (rsp.done) begin
                    hour_reg <= rsp.rem[4:0];
                    days_reg <= rsp.quo[15:0];
                end
            end
            S_CYC: begin
                if (rsp.done) begin
                    cyc_reg <= rsp.quo[5:0];
                    rem_reg <= rsp.rem;
                    yic_reg <= '0;
                end
            end
            S_WDAY: if (rsp.done) wday_reg <= rsp.rem[2:0];
            S_YEAR: begin
                if (rem_reg < DaysPerYear || yic_reg == LastYearIdx ||
                    (yic_reg == LeapYearIdx && rem_reg == DaysPerYear)) begin
                    doy_reg   <= rem_reg[8:0];
                    month_reg <= '0;
                end else begin
                    rem_reg <= rem_reg - ((yic_reg == LeapYearIdx) ? DaysLeap : DaysPerYear);
                    yic_reg <= yic_reg + 2'd1;
                end
            end
            S_MONTH: begin
                month_reg <= month_reg + 4'd1;
                if ({6'b0, mlen} <= rem_reg) begin
                    rem_reg <= rem_reg - {6'b0, mlen};
                end
            end
            S_WEEK: if (rsp.done) week_reg <= rsp.quo[5:0] + 6'd1;
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_second_of_minute <= sec_reg;
            m_minute_of_hour   <= min_reg;
            m_hour_of_day      <= hour_reg;
            m_day_of_month     <= rem_reg[4:0] + 5'd1;
            m_month_number     <= month_reg;
            m_year_number      <= EpochYear + {4'b0, cyc_reg, 2'b00} + {10'b0, yic_reg};
            m_ordinal_day      <= ordinal;
            m_weekday_number   <= wday_reg;
            m_week_number      <= week_reg;
            m_zone_out         <= zone_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ----- sv/ecd_checker.sv -----
`default_nettype none
`include "epoch_seconds_to_calendar_date_defines.svh"

module ecd_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [5:0]         m_second_of_minute,
    input  logic [5:0]         m_minute_of_hour,
    input  logic [4:0]         m_hour_of_day,
    input  logic [4:0]         m_day_of_month,
    input  logic [3:0]         m_month_number,
    input  logic [11:0]        m_year_number,
    input  logic [8:0]         m_ordinal_day,
    input  logic [2:0]         m_weekday_number,
    input  logic [5:0]         m_week_number,
    input  logic signed [16:0] m_zone_out
);

    logic [72:0] m_fields;
    logic        m_sane;
    logic        m_stall;
    logic        s_fire;

    assign m_fields = {m_second_of_minute, m_minute_of_hour, m_hour_of_day, m_day_of_month,
                       m_month_number, m_year_number, m_ordinal_day, m_weekday_number,
                       m_week_number, m_zone_out};

    assign m_sane = m_second_of_minute < 6'd60 && m_minute_of_hour < 6'd60 &&
                    m_hour_of_day < 5'd24 && m_day_of_month != 5'd0 &&
                    m_month_number >= 4'd1 && m_month_number <= 4'd12 &&
                    m_ordinal_day != 9'd0 && m_weekday_number < 3'd7 &&
                    m_week_number != 6'd0;

    assign m_stall = m_valid && !m_ready;
    assign s_fire  = s_valid && s_ready;

    // stalled result must hold
    `ECD_ASSERT_NEXT(a_out_hold, m_stall, m_valid && $stable(m_fields), "stalled result changed")

    // one transaction at a time: busy right after an accept
    `ECD_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_ready, "second accept while busy")

    // m_valid is set only from the output state, so no result can appear right after accept
    `ECD_ASSERT_NEXT(a_no_instant_result, s_fire, !$rose(m_valid), "result appeared too early")

    // a fresh result carries a sane date
    `ECD_ASSERT_NOW(a_result_range, $rose(m_valid), m_sane, "result field out of range")

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (.*);

`default_nettype wire
